[rtl/brg_pkg.sv]
// Shared types, constants and the arctangent table for the bearing block.
// Depends on nothing; every other file imports it.
`default_nettype none

package brg_pkg;

    // Sizing of the datapath
    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STAGES   = 16;

    localparam int BEARING_W   = 16;
    localparam int GUARD       = 20;
    localparam int ZFRAC       = 24;
    // Sign bit plus headroom for the diagonal magnitude times the CORDIC gain
    localparam int XW          = COORD_WIDTH + GUARD + 3;
    localparam int ZW          = 32;
    localparam int FW          = 36;
    localparam int IDX_W       = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam int TAB_IDX_W   = 5;
    localparam int ROUND_SHIFT = ZFRAC - ANGLE_FRAC_BITS;

    // Angle constants in the accumulator format
    localparam logic signed [ZW-1:0] DEG90_Z     = ZW'(90) << ZFRAC;
    localparam logic [FW-1:0]        DEG180_F    = FW'(180) << ZFRAC;
    localparam logic [FW-1:0]        DEG360_F    = FW'(360) << ZFRAC;
    localparam logic [FW-1:0]        ROUND_HALF  = FW'(1) << (ROUND_SHIFT - 1);
    localparam logic [FW-1:0]        FULL_CIRCLE = FW'(360) << ANGLE_FRAC_BITS;

    // Quadrant rule codes
    localparam logic [1:0] Q_PLAIN     = 2'd0;
    localparam logic [1:0] Q_180_MINUS = 2'd1;
    localparam logic [1:0] Q_180_PLUS  = 2'd2;
    localparam logic [1:0] Q_360_MINUS = 2'd3;

    // Source of the first-quadrant angle
    localparam logic [1:0] A_CORDIC = 2'd0;
    localparam logic [1:0] A_ZERO   = 2'd1;
    localparam logic [1:0] A_NINETY = 2'd2;

    typedef struct packed {
        logic [1:0] quad;
        logic [1:0] asel;
    } t_side;

    typedef struct packed {
        logic                 valid;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        t_side                side;
    } t_cordic;

    // atan(2^-i) in degrees, 24 fraction bits, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_deg(input logic [TAB_IDX_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = ZW'(754974720);
            5'd1:  v = ZW'(445687602);
            5'd2:  v = ZW'(235489088);
            5'd3:  v = ZW'(119537938);
            5'd4:  v = ZW'(60000934);
            5'd5:  v = ZW'(30029717);
            5'd6:  v = ZW'(15018523);
            5'd7:  v = ZW'(7509720);
            5'd8:  v = ZW'(3754917);
            5'd9:  v = ZW'(1877466);
            5'd10: v = ZW'(938734);
            5'd11: v = ZW'(469367);
            5'd12: v = ZW'(234684);
            5'd13: v = ZW'(117342);
            5'd14: v = ZW'(58671);
            5'd15: v = ZW'(29335);
            5'd16: v = ZW'(14668);
            5'd17: v = ZW'(7334);
            5'd18: v = ZW'(3667);
            5'd19: v = ZW'(1833);
            5'd20: v = ZW'(917);
            5'd21: v = ZW'(458);
            5'd22: v = ZW'(229);
            5'd23: v = ZW'(115);
            5'd24: v = ZW'(57);
            5'd25: v = ZW'(29);
            5'd26: v = ZW'(14);
            5'd27: v = ZW'(7);
            5'd28: v = ZW'(4);
            5'd29: v = ZW'(2);
            5'd30: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/brg_if.sv]
// Request and result channel interfaces for the bearing block.
// Depends on brg_pkg for field widths.
`default_nettype none

interface brg_req_if import brg_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] ref_x;
    logic signed [COORD_WIDTH-1:0] ref_y;
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;

    modport source (output valid, ref_x, ref_y, target_x, target_y, input ready);
    modport sink   (input valid, ref_x, ref_y, target_x, target_y, output ready);
endinterface

interface brg_res_if import brg_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [BEARING_W-1:0] bearing;

    modport source (output valid, bearing, input ready);
    modport sink   (input valid, bearing, output ready);
endinterface

`default_nettype wire

[rtl/brg_front.sv]
// Front end: coordinate differences, magnitudes and quadrant classification.
// Depends on brg_pkg and brg_req_if; feeds the first CORDIC cell.
`default_nettype none

module brg_front import brg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    brg_req_if.sink    i_req,
    output t_cordic    o_stage
);

    logic signed [COORD_WIDTH:0]   w_dx;
    logic signed [COORD_WIDTH:0]   w_dy;
    logic signed [COORD_WIDTH:0]   w_dx_abs;
    logic signed [COORD_WIDTH:0]   w_dy_abs;
    t_cordic                       n_stage;
    t_cordic                       r_stage;

    // Accept a request whenever the pipe advances
    assign i_req.ready = i_en;

    assign w_dx = {i_req.target_x[COORD_WIDTH-1], i_req.target_x}
                - {i_req.ref_x[COORD_WIDTH-1], i_req.ref_x};
    assign w_dy = {i_req.target_y[COORD_WIDTH-1], i_req.target_y}
                - {i_req.ref_y[COORD_WIDTH-1], i_req.ref_y};
    assign w_dx_abs = (w_dx < 0) ? -w_dx : w_dx;
    assign w_dy_abs = (w_dy < 0) ? -w_dy : w_dy;

    // Scale magnitudes into the guard format and classify the quadrant
    always_comb begin
        n_stage.valid = i_req.valid;
        n_stage.x     = $signed({{(XW-COORD_WIDTH-GUARD){1'b0}},
                                 w_dx_abs[COORD_WIDTH-1:0], {GUARD{1'b0}}});
        n_stage.y     = $signed({{(XW-COORD_WIDTH-GUARD){1'b0}},
                                 w_dy_abs[COORD_WIDTH-1:0], {GUARD{1'b0}}});
        n_stage.z     = '0;

        if (w_dx < 0 && w_dy <= 0) begin
            n_stage.side.quad = Q_180_MINUS;
        end else if (w_dx <= 0 && w_dy > 0) begin
            n_stage.side.quad = Q_180_PLUS;
        end else if (w_dx > 0 && w_dy > 0) begin
            n_stage.side.quad = Q_360_MINUS;
        end else begin
            n_stage.side.quad = Q_PLAIN;
        end

        // Horizontal and vertical lines bypass the CORDIC result
        if (w_dy == 0) begin
            n_stage.side.asel = A_ZERO;
        end else if (w_dx == 0) begin
            n_stage.side.asel = A_NINETY;
        end else begin
            n_stage.side.asel = A_CORDIC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

[rtl/brg_cell.sv]
// One vectoring CORDIC rotation cell; the chain is built from identical copies.
// Depends on brg_pkg for the stage bundle and the arctangent table.
`default_nettype none

module brg_cell import brg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [IDX_W-1:0] i_index,
    input  t_cordic          i_prev,
    output t_cordic          o_next
);

    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;
    logic signed [ZW-1:0] w_step;
    t_cordic              n_stage;
    t_cordic              r_stage;

    assign w_xs   = i_prev.x >>> i_index;
    assign w_ys   = i_prev.y >>> i_index;
    assign w_step = atan_deg(TAB_IDX_W'(i_index));

    // Rotate toward the x axis, accumulating the angle
    always_comb begin
        n_stage = i_prev;
        if (i_prev.y >= 0) begin
            n_stage.x = i_prev.x + w_ys;
            n_stage.y = i_prev.y - w_xs;
            n_stage.z = i_prev.z + w_step;
        end else begin
            n_stage.x = i_prev.x - w_ys;
            n_stage.y = i_prev.y + w_xs;
            n_stage.z = i_prev.z - w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_next = r_stage;

endmodule

`default_nettype wire

[rtl/brg_back.sv]
// Back end: clamp, quadrant fold, rounding, wrap and the result register.
// Depends on brg_pkg and brg_res_if; takes the last CORDIC cell output.
`default_nettype none

module brg_back import brg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cordic    i_stage,
    brg_res_if.source  o_res,
    output logic       o_en
);

    logic signed [ZW-1:0] w_a;
    logic [FW-1:0]        w_a_ext;
    logic [FW-1:0]        n_full;
    logic [FW-1:0]        w_sum;
    logic [FW-1:0]        w_rnd;
    logic [FW-1:0]        w_wrap;
    logic                 r_a_valid;
    logic [FW-1:0]        r_full;
    logic                 r_out_valid;
    logic [BEARING_W-1:0] r_bearing;

    // Advance the whole pipe unless a finished result is held back
    assign o_en = !r_out_valid || o_res.ready;

    // Pick and clamp the first-quadrant angle
    always_comb begin
        case (i_stage.side.asel)
            A_ZERO:   w_a = '0;
            A_NINETY: w_a = DEG90_Z;
            default: begin
                if (i_stage.z < 0) begin
                    w_a = '0;
                end else if (i_stage.z > DEG90_Z) begin
                    w_a = DEG90_Z;
                end else begin
                    w_a = i_stage.z;
                end
            end
        endcase
    end

    assign w_a_ext = FW'($unsigned(w_a));

    // Fold into the full circle
    always_comb begin
        case (i_stage.side.quad)
            Q_180_MINUS: n_full = DEG180_F - w_a_ext;
            Q_180_PLUS:  n_full = DEG180_F + w_a_ext;
            Q_360_MINUS: n_full = DEG360_F - w_a_ext;
            default:     n_full = w_a_ext;
        endcase
    end

    // Round half up and wrap a full turn to zero
    assign w_sum  = r_full + ROUND_HALF;
    assign w_rnd  = w_sum >> ROUND_SHIFT;
    assign w_wrap = (w_rnd >= FULL_CIRCLE) ? (w_rnd - FULL_CIRCLE) : w_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_en) begin
            r_a_valid   <= i_stage.valid;
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_full    <= n_full;
            r_bearing <= w_wrap[BEARING_W-1:0];
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.bearing = r_bearing;

endmodule

`default_nettype wire

[rtl/bearing_angle_degrees_top.sv]
// Top level of the bearing block: front end, chain of CORDIC cells, back end.
// Depends on brg_pkg, brg_if, brg_front, brg_cell and brg_back.
//
//   channel   modport        payload                              direction
//   i_req     brg_req_if     ref_x, ref_y, target_x, target_y     in
//   o_res     brg_res_if     bearing (degrees x 2^frac bits)      out
//
// One request is taken every cycle unless the pipe is stalled; each result passes through
// the front register, one register per cell and two back registers.
// Reset clears only the valid flags of every stage and of the result register.
// A result held at o_res stalls the whole pipe for that cycle, and i_req.ready
// drops with it; bubbles travel through the chain like requests.
`default_nettype none

module bearing_angle_degrees_top import brg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    brg_req_if.sink    i_req,
    brg_res_if.source  o_res
);

    logic                     w_en;
    t_cordic                  w_stage [0:CORDIC_STAGES];
    logic [CORDIC_STAGES:0]   w_valid_chain;

    brg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_req   (i_req),
        .o_stage (w_stage[0])
    );

    // Build the rotation chain
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        brg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_index (IDX_W'(g)),
            .i_prev  (w_stage[g]),
            .o_next  (w_stage[g+1])
        );
    end

    for (genvar v = 0; v <= CORDIC_STAGES; v++) begin : g_valid
        assign w_valid_chain[v] = w_stage[v].valid;
    end

    brg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_stage[CORDIC_STAGES]),
        .o_res   (o_res),
        .o_en    (w_en)
    );

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

    // A delivered bearing never reaches a full turn
    a_bearing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (FW'(o_res.bearing) < FULL_CIRCLE))
        else $error("bearing out of range");

    // A stall freezes the occupancy of the chain
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_valid_chain))
        else $error("chain moved while stalled");

endmodule

`default_nettype wire

[tb/sv/bearing_angle_degrees_top_tb.sv]
// Self-checking testbench for bearing_angle_degrees_top: directed table, then random requests.
// Depends on brg_pkg and brg_if from the RTL; predicts each bearing not given in the table with its own CORDIC copy.
// Runs three pacing phases, one long result hold-off, and drains the pipe between phases.
`default_nettype none

module bearing_angle_degrees_top_tb;
    import brg_pkg::*;

    // Predictor fixed-point formats
    localparam int ANG_Q       = 24;
    localparam int GUARD_BITS  = 20;
    localparam int RND_SHIFT   = ANG_Q - ANGLE_FRAC_BITS;
    localparam int N_DIRECTED  = 24;
    localparam int N_PER_PHASE = 600;
    localparam int N_PHASES    = 3;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2 * (CORDIC_STAGES + 3);
    localparam int HOLD_CYCLES = 400;

    localparam logic [BEARING_W-1:0] BRG_0   = BEARING_W'(0);
    localparam logic [BEARING_W-1:0] BRG_90  = BEARING_W'(90 << ANGLE_FRAC_BITS);
    localparam logic [BEARING_W-1:0] BRG_180 = BEARING_W'(180 << ANGLE_FRAC_BITS);
    localparam logic [BEARING_W-1:0] BRG_270 = BEARING_W'(270 << ANGLE_FRAC_BITS);

    // Point classes for the coverage summary
    localparam int CLS_EQUAL = 0;
    localparam int CLS_AXIS  = 1;
    localparam int CLS_Q1    = 2;
    localparam int CLS_Q2    = 3;
    localparam int CLS_Q3    = 4;
    localparam int CLS_Q4    = 5;

    typedef struct {
        int                   rx;
        int                   ry;
        int                   tx;
        int                   ty;
        bit                   known;
        logic [BEARING_W-1:0] bearing;
    } t_dir_row;

    logic clk;
    logic rst_n;

    brg_req_if req_if();
    brg_res_if res_if();

    bearing_angle_degrees_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // atan(2^-i) in degrees, 24 fraction bits
    longint atan_q24 [0:31] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
        117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
        115, 57, 29, 14, 7, 4, 2, 1, 0
    };

    // Directed requests: equal points, axes, extremes, diagonals, near-axis angles
    t_dir_row directed_rows [N_DIRECTED] = '{
        '{0, 0, 0, 0, 1'b1, BRG_0},
        '{-32768, -32768, -32768, -32768, 1'b1, BRG_0},
        '{0, 0, 100, 0, 1'b1, BRG_0},
        '{100, 5, -3, 5, 1'b1, BRG_180},
        '{0, 0, 0, -7, 1'b1, BRG_90},
        '{0, 0, 0, 7, 1'b1, BRG_270},
        '{-32768, 0, 32767, 0, 1'b1, BRG_0},
        '{32767, 0, -32768, 0, 1'b1, BRG_180},
        '{0, 32767, 0, -32768, 1'b1, BRG_90},
        '{0, -32768, 0, 32767, 1'b1, BRG_270},
        '{-1, -1, -1, 0, 1'b1, BRG_270},
        '{0, 0, 1, -1, 1'b0, BRG_0},
        '{0, 0, -1, -1, 1'b0, BRG_0},
        '{0, 0, -1, 1, 1'b0, BRG_0},
        '{0, 0, 1, 1, 1'b0, BRG_0},
        '{-32768, 32767, 32767, -32768, 1'b0, BRG_0},
        '{32767, -32768, -32768, 32767, 1'b0, BRG_0},
        '{-32768, 0, 32767, 1, 1'b0, BRG_0},
        '{-32768, 0, 32767, -1, 1'b0, BRG_0},
        '{32767, 0, -32768, 1, 1'b0, BRG_0},
        '{0, -32768, 1, 32767, 1'b0, BRG_0},
        '{0, -32768, -1, 32767, 1'b0, BRG_0},
        '{-1, 0, 0, -1, 1'b0, BRG_0},
        '{1234, -4321, -30000, 29999, 1'b0, BRG_0}
    };

    logic [BEARING_W-1:0] pending_bearings [$];
    logic [BEARING_W-1:0] want_bearing;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int mismatches;
    int requests_sent;
    int results_seen;
    int class_count [6];
    bit timed_out;

    // Bearing of target seen from reference, degrees times 2^ANGLE_FRAC_BITS
    function automatic logic [BEARING_W-1:0] predict_bearing(
        input logic signed [COORD_WIDTH-1:0] rx,
        input logic signed [COORD_WIDTH-1:0] ry,
        input logic signed [COORD_WIDTH-1:0] tx,
        input logic signed [COORD_WIDTH-1:0] ty
    );
        longint dx;
        longint dy;
        longint a;
        longint full;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint unsigned r;
        dx = longint'(tx) - longint'(rx);
        dy = longint'(ty) - longint'(ry);
        if (dx == 0 && dy == 0)
            return BRG_0;
        if (dy == 0) begin
            a = 0;
        end else if (dx == 0) begin
            a = longint'(90) <<< ANG_Q;
        end else begin
            // Vectoring CORDIC on the magnitudes
            x = (dx < 0 ? -dx : dx) <<< GUARD_BITS;
            y = (dy < 0 ? -dy : dy) <<< GUARD_BITS;
            z = 0;
            for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_q24[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_q24[i];
                end
            end
            if (z < 0)
                z = 0;
            if (z > (longint'(90) <<< ANG_Q))
                z = longint'(90) <<< ANG_Q;
            a = z;
        end
        // Fold into the full circle, y grows downward
        if (dx < 0 && dy <= 0)
            full = (longint'(180) <<< ANG_Q) - a;
        else if (dx <= 0 && dy > 0)
            full = (longint'(180) <<< ANG_Q) + a;
        else if (dx > 0 && dy > 0)
            full = (longint'(360) <<< ANG_Q) - a;
        else
            full = a;
        r = (unsigned'(full) + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
        if (r >= (64'd360 << ANGLE_FRAC_BITS))
            r = r - (64'd360 << ANGLE_FRAC_BITS);
        return BEARING_W'(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [BEARING_W-1:0] exp_b,
                                   input logic [BEARING_W-1:0] got_b);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected bearing %0d, got %0d", $realtime, what, exp_b, got_b);
    endtask

    // Offer one request, wait for it to be taken, then queue its expected bearing
    task automatic send_request(
        input logic signed [COORD_WIDTH-1:0] rx,
        input logic signed [COORD_WIDTH-1:0] ry,
        input logic signed [COORD_WIDTH-1:0] tx,
        input logic signed [COORD_WIDTH-1:0] ty,
        input bit                            known,
        input logic [BEARING_W-1:0]          known_bearing
    );
        int dx;
        int dy;
        while (int'($urandom_range(99)) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.ref_x    <= rx;
        req_if.ref_y    <= ry;
        req_if.target_x <= tx;
        req_if.target_y <= ty;
        do @(posedge clk); while (!req_if.ready);
        pending_bearings.push_back(known ? known_bearing : predict_bearing(rx, ry, tx, ty));
        requests_sent++;
        dx = int'(tx) - int'(rx);
        dy = int'(ty) - int'(ry);
        if (dx == 0 && dy == 0)
            class_count[CLS_EQUAL]++;
        else if (dx == 0 || dy == 0)
            class_count[CLS_AXIS]++;
        else if (dx > 0)
            class_count[dy < 0 ? CLS_Q1 : CLS_Q4]++;
        else
            class_count[dy < 0 ? CLS_Q2 : CLS_Q3]++;
    endtask

    // Stop offering and wait for every queued bearing to come back, or for the drain limit to run out
    task automatic drain_results();
        int waited;
        waited = 0;
        req_if.valid <= 1'b0;
        while (pending_bearings.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
    endtask

    task automatic gen_random_request(
        output logic signed [COORD_WIDTH-1:0] rx,
        output logic signed [COORD_WIDTH-1:0] ry,
        output logic signed [COORD_WIDTH-1:0] tx,
        output logic signed [COORD_WIDTH-1:0] ty
    );
        int kind;
        int d;
        int ox;
        int oy;
        int extremes [5];
        extremes = '{-32768, 32767, 0, -1, 1};
        kind = $urandom_range(99);
        rx = COORD_WIDTH'($urandom);
        ry = COORD_WIDTH'($urandom);
        tx = COORD_WIDTH'($urandom);
        ty = COORD_WIDTH'($urandom);
        if (kind < 40) begin
            // fully random points
        end else if (kind < 60) begin
            // short vectors
            tx = COORD_WIDTH'(int'(rx) + int'($urandom_range(16)) - 8);
            ty = COORD_WIDTH'(int'(ry) + int'($urandom_range(16)) - 8);
        end else if (kind < 70) begin
            // horizontal or vertical lines
            if ($urandom_range(1) == 0)
                tx = rx;
            else
                ty = ry;
        end else if (kind < 75) begin
            tx = rx;
            ty = ry;
        end else if (kind < 85) begin
            rx = COORD_WIDTH'(extremes[$urandom_range(4)]);
            ry = COORD_WIDTH'(extremes[$urandom_range(4)]);
            tx = COORD_WIDTH'(extremes[$urandom_range(4)]);
            ty = COORD_WIDTH'(extremes[$urandom_range(4)]);
        end else begin
            // diagonals and angles close to an axis
            d  = $urandom_range(16383, 1);
            ox = int'($urandom_range(32767)) - 16384;
            oy = int'($urandom_range(32767)) - 16384;
            case ($urandom_range(2))
                0: begin
                    tx = COORD_WIDTH'(ox + ($urandom_range(1) ? d : -d));
                    ty = COORD_WIDTH'(oy + ($urandom_range(1) ? d : -d));
                end
                1: begin
                    tx = COORD_WIDTH'(ox + ($urandom_range(1) ? d : -d));
                    ty = COORD_WIDTH'(oy + ($urandom_range(1) ? 1 : -1));
                end
                default: begin
                    tx = COORD_WIDTH'(ox + ($urandom_range(1) ? 1 : -1));
                    ty = COORD_WIDTH'(oy + ($urandom_range(1) ? d : -d));
                end
            endcase
            rx = COORD_WIDTH'(ox);
            ry = COORD_WIDTH'(oy);
        end
    endtask

    // Clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Check each taken result, then pick the next ready; hold off while a stall is armed
    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            if (pending_bearings.size() == 0) begin
                report_mismatch("result with nothing outstanding", BRG_0, res_if.bearing);
            end else begin
                want_bearing = pending_bearings.pop_front();
                results_seen++;
                if (res_if.bearing !== want_bearing)
                    report_mismatch("bearing mismatch", want_bearing, res_if.bearing);
            end
        end
        if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else begin
            res_if.ready <= (int'($urandom_range(99)) >= recv_idle_pct);
        end
    end

    // Fail the run if it hangs
    initial begin
        timed_out = 1'b0;
        #10_000_000;
        timed_out = 1'b1;
        $display("bearing_angle_degrees_top_tb NOT OK");
        $finish;
    end

    // Stimulus
    initial begin
        logic signed [COORD_WIDTH-1:0] rx;
        logic signed [COORD_WIDTH-1:0] ry;
        logic signed [COORD_WIDTH-1:0] tx;
        logic signed [COORD_WIDTH-1:0] ty;
        clk             = 1'b0;
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.ref_x    = '0;
        req_if.ref_y    = '0;
        req_if.target_x = '0;
        req_if.target_y = '0;
        res_if.ready    = 1'b0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_left       = 0;
        mismatches      = 0;
        requests_sent   = 0;
        results_seen    = 0;
        foreach (class_count[k])
            class_count[k] = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[i]) begin
            send_request(COORD_WIDTH'(directed_rows[i].rx), COORD_WIDTH'(directed_rows[i].ry),
                         COORD_WIDTH'(directed_rows[i].tx), COORD_WIDTH'(directed_rows[i].ty),
                         directed_rows[i].known, directed_rows[i].bearing);
        end
        drain_results();

        // Random phases: slow receiver, then slow sender, then full rate
        for (int phase = 0; phase < N_PHASES; phase++) begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 82 : 0;
            recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 14 : 0;
            if (phase == N_PHASES - 1)
                hold_left = HOLD_CYCLES;
            for (int n = 0; n < N_PER_PHASE; n++) begin
                gen_random_request(rx, ry, tx, ty);
                send_request(rx, ry, tx, ty, 1'b0, BRG_0);
            end
            drain_results();
        end

        // Let any stray result show up
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_bearings.size() != 0) begin
            mismatches += pending_bearings.size();
            $display("%0d expected bearings never arrived", pending_bearings.size());
        end

        $display("Covered %0d requests and %0d results: %0d equal points, %0d on an axis,",
                 requests_sent, results_seen, class_count[CLS_EQUAL], class_count[CLS_AXIS]);
        $display("quadrants I/II/III/IV %0d/%0d/%0d/%0d; %0d mismatches",
                 class_count[CLS_Q1], class_count[CLS_Q2], class_count[CLS_Q3],
                 class_count[CLS_Q4], mismatches);
        if (mismatches == 0 && !timed_out) begin
            $display("bearing_angle_degrees_top_tb OK");
        end else begin
            $display("bearing_angle_degrees_top_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
